/* src/crl_pkg.sv */
package crl_pkg;

  // Default sizes of the node pool and of a stored value.
  localparam int unsigned CAPACITY_DEF    = 64;
  localparam int unsigned VALUE_WIDTH_DEF = 32;

  // Fixed widths of the item fields.
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned STEPS_W = 16;
  localparam int unsigned DCNT_W  = $clog2(STEPS_W);

  // Request kinds.
  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_ROTATE = 2'd3
  } req_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NONE       = 4'd0,
    CMD_LOAD       = 4'd1,
    CMD_READ       = 4'd2,
    CMD_PUSH_W1    = 4'd3,
    CMD_PUSH_W2    = 4'd4,
    CMD_POP_W1     = 4'd5,
    CMD_POP_W2     = 4'd6,
    CMD_GRAB       = 4'd7,
    CMD_FLAG_EMPTY = 4'd8,
    CMD_FLAG_FULL  = 4'd9,
    CMD_DIV_INIT   = 4'd10,
    CMD_DIV_STEP   = 4'd11,
    CMD_WALK_UPD   = 4'd12,
    CMD_OUT        = 4'd13
  } cmd_e;

  // Status from the datapath to the controller.
  typedef struct packed {
    req_e req;
    logic empty;
    logic full;
    logic div_last;
    logic rem_zero;
  } dp_sts_t;

endpackage

/* src/crl_dp.sv */
module crl_dp #(
  parameter int unsigned CAPACITY    = crl_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = crl_pkg::VALUE_WIDTH_DEF,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  crl_pkg::cmd_e               cmd_i,
  output crl_pkg::dp_sts_t            sts_o,
  input  logic [1:0]                  req_type_i,
  input  logic signed [crl_pkg::DATA_W-1:0] data_in_i,
  input  logic                        clockwise_i,
  input  logic [crl_pkg::STEPS_W-1:0] steps_i,
  output logic signed [crl_pkg::DATA_W-1:0] data_out_o,
  output logic [1:0]                  status_o,
  output logic [CW-1:0]               occupancy_o
);
  import crl_pkg::*;

  // Node pool memories.
  logic [AW-1:0]          next_mem [CAPACITY];
  logic [AW-1:0]          prev_mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] val_mem  [CAPACITY];

  // Ring state.
  logic [AW-1:0] head_q, head_d, free_q, free_d;
  logic [CW-1:0] count_q, count_d, hw_q, hw_d;

  // Captured request and working registers.
  req_e                   req_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic                   cw_q;
  logic [STEPS_W-1:0]     sh_q;
  logic [AW-1:0]          n_q, y_q;
  logic [AW-1:0]          nrd_a_q, nrd_b_q, prd_q;
  logic [VALUE_WIDTH-1:0] vrd_q;
  logic [CW-1:0]          rem_q;
  logic [DCNT_W-1:0]      dcnt_q;
  logic [DATA_W-1:0]      dout_q;
  status_e                stat_q;

  // Write ports.
  logic                   next_we, prev_we, val_we;
  logic [AW-1:0]          next_wa, next_wd, prev_wa, prev_wd;

  logic          empty, untouched;
  logic [AW-1:0] x_sel, y_sel, free_inc;
  logic [CW:0]   div_r;
  logic [CW:0]   div_s;
  logic [63:0]   din_ext, vrd_ext;

  assign empty     = (count_q == '0);
  assign untouched = (CW'(free_q) == hw_q);
  assign free_inc  = (free_q == AW'(CAPACITY - 1)) ? '0 : free_q + AW'(1);
  assign x_sel     = empty ? free_q : (cw_q ? head_q : prd_q);
  assign y_sel     = empty ? free_q : (cw_q ? nrd_b_q : head_q);
  assign din_ext   = {32'b0, data_in_i};
  assign vrd_ext   = 64'(vrd_q);

  // One restoring division step of steps by the count.
  assign div_r = {rem_q, sh_q[STEPS_W-1]};
  assign div_s = div_r - {1'b0, count_q};

  assign sts_o.req      = req_q;
  assign sts_o.empty    = empty;
  assign sts_o.full     = (count_q == CW'(CAPACITY));
  assign sts_o.div_last = (dcnt_q == DCNT_W'(STEPS_W - 1));
  assign sts_o.rem_zero = (rem_q == '0);

  // Memory write selection and ring state updates.
  always_comb begin
    next_we = 1'b0;
    prev_we = 1'b0;
    val_we  = 1'b0;
    next_wa = x_sel;
    next_wd = free_q;
    prev_wa = free_q;
    prev_wd = x_sel;
    head_d  = head_q;
    free_d  = free_q;
    count_d = count_q;
    hw_d    = hw_q;
    case (cmd_i)
      CMD_PUSH_W1: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        if (untouched) begin
          free_d = free_inc;
          hw_d   = hw_q + CW'(1);
        end else begin
          free_d = nrd_a_q;
        end
      end
      CMD_PUSH_W2: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        val_we  = 1'b1;
        next_wa = n_q;
        next_wd = y_q;
        prev_wa = y_q;
        prev_wd = n_q;
        if (empty) head_d = n_q;
        count_d = count_q + CW'(1);
      end
      CMD_POP_W1: begin
        next_we = 1'b1;
        prev_we = 1'b1;
        next_wa = prd_q;
        next_wd = nrd_b_q;
        prev_wa = nrd_b_q;
        prev_wd = prd_q;
      end
      CMD_POP_W2: begin
        next_we = 1'b1;
        next_wa = head_q;
        next_wd = free_q;
        free_d  = head_q;
        head_d  = (count_q == CW'(1)) ? '0 : (cw_q ? nrd_b_q : prd_q);
        count_d = count_q - CW'(1);
      end
      CMD_WALK_UPD: head_d = cw_q ? nrd_b_q : prd_q;
      default: ;
    endcase
  end

  // Ring state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      free_q  <= '0;
      count_q <= '0;
      hw_q    <= '0;
    end else begin
      head_q  <= head_d;
      free_q  <= free_d;
      count_q <= count_d;
      hw_q    <= hw_d;
    end
  end

  // Memories with registered reads.
  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (cmd_i == CMD_READ) begin
      nrd_a_q <= next_mem[free_q];
      nrd_b_q <= next_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (cmd_i == CMD_READ) prd_q <= prev_mem[head_q];
  end

  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[n_q] <= val_q;
    if (cmd_i == CMD_READ) vrd_q <= val_mem[head_q];
  end

  // Working registers and the result.
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        req_q  <= req_e'(req_type_i);
        val_q  <= din_ext[VALUE_WIDTH-1:0];
        cw_q   <= clockwise_i;
        sh_q   <= steps_i;
        dout_q <= '0;
        stat_q <= ST_OK;
      end
      CMD_PUSH_W1: begin
        n_q <= free_q;
        y_q <= y_sel;
      end
      CMD_POP_W1, CMD_GRAB: dout_q <= vrd_ext[DATA_W-1:0];
      CMD_FLAG_EMPTY: stat_q <= ST_EMPTY;
      CMD_FLAG_FULL:  stat_q <= ST_FULL;
      CMD_DIV_INIT: begin
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      CMD_DIV_STEP: begin
        rem_q  <= div_s[CW] ? div_r[CW-1:0] : div_s[CW-1:0];
        sh_q   <= {sh_q[STEPS_W-2:0], 1'b0};
        dcnt_q <= dcnt_q + DCNT_W'(1);
      end
      CMD_WALK_UPD: rem_q <= rem_q - CW'(1);
      CMD_OUT: begin
        data_out_o  <= dout_q;
        status_o    <= stat_q;
        occupancy_o <= count_q;
      end
      default: ;
    endcase
  end

endmodule

/* src/crl_ctrl.sv */
module crl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  crl_pkg::dp_sts_t sts_i,
  output crl_pkg::cmd_e    cmd_o
);
  import crl_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_DECODE = 14'b00000000000010,
    S_PW1    = 14'b00000000000100,
    S_PW2    = 14'b00000000001000,
    S_POPW1  = 14'b00000000010000,
    S_POPW2  = 14'b00000000100000,
    S_PEEK   = 14'b00000001000000,
    S_DIV    = 14'b00000010000000,
    S_WCHK   = 14'b00000100000000,
    S_WUPD   = 14'b00001000000000,
    S_DONE   = 14'b00010000000000,
    S_DIVI   = 14'b00100000000000,
    S_SPARE1 = 14'b01000000000000,
    S_SPARE2 = 14'b10000000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts_i.req)
          REQ_PUSH: begin
            if (sts_i.full) begin
              cmd_o   = CMD_FLAG_FULL;
              state_d = S_DONE;
            end else begin
              cmd_o   = CMD_READ;
              state_d = S_PW1;
            end
          end
          REQ_POP, REQ_PEEK: begin
            if (sts_i.empty) begin
              cmd_o   = CMD_FLAG_EMPTY;
              state_d = S_DONE;
            end else begin
              cmd_o   = CMD_READ;
              state_d = (sts_i.req == REQ_POP) ? S_POPW1 : S_PEEK;
            end
          end
          default: state_d = sts_i.empty ? S_DONE : S_DIVI;
        endcase
      end
      S_PW1: begin
        cmd_o   = CMD_PUSH_W1;
        state_d = S_PW2;
      end
      S_PW2: begin
        cmd_o   = CMD_PUSH_W2;
        state_d = S_DONE;
      end
      S_POPW1: begin
        cmd_o   = CMD_POP_W1;
        state_d = S_POPW2;
      end
      S_POPW2: begin
        cmd_o   = CMD_POP_W2;
        state_d = S_DONE;
      end
      S_PEEK: begin
        cmd_o   = CMD_GRAB;
        state_d = S_DONE;
      end
      S_DIVI: begin
        cmd_o   = CMD_DIV_INIT;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o = CMD_DIV_STEP;
        if (sts_i.div_last) state_d = S_WCHK;
      end
      S_WCHK: begin
        if (sts_i.rem_zero) begin
          state_d = S_DONE;
        end else begin
          cmd_o   = CMD_READ;
          state_d = S_WUPD;
        end
      end
      S_WUPD: begin
        cmd_o   = CMD_WALK_UPD;
        state_d = S_WCHK;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o   = CMD_OUT;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output slot valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o == CMD_OUT) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* src/circular_doubly_linked_ring_core.sv */
// Circular doubly linked ring of up to CAPACITY values with push, pop, peek and
// rotate requests, one result item per request item. A request is taken only
// while the sequencer is idle; one finished result may wait in the output
// register meanwhile. A full or empty refusal skips the memory access; a rotate
// of a non-empty ring runs a bit-serial remainder unit on steps and the count,
// then one link memory read per walked node. Link and value memories are written
// on one port each; the reset free list comes from an allocation watermark, so
// there is no clearing pass after reset.
module circular_doubly_linked_ring_core #(
  parameter int unsigned CAPACITY    = crl_pkg::CAPACITY_DEF,
  parameter int unsigned VALUE_WIDTH = crl_pkg::VALUE_WIDTH_DEF,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        req_type_i,
  input  logic signed [crl_pkg::DATA_W-1:0] data_in_i,
  input  logic                              clockwise_i,
  input  logic [crl_pkg::STEPS_W-1:0]       steps_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [crl_pkg::DATA_W-1:0] data_out_o,
  output logic [1:0]                        status_o,
  output logic [CW-1:0]                     occupancy_o
);
  import crl_pkg::*;

  cmd_e    cmd;
  dp_sts_t sts;

  // Sequencer.
  crl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Node pool and ring registers.
  crl_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_type_i  (req_type_i),
    .data_in_i   (data_in_i),
    .clockwise_i (clockwise_i),
    .steps_i     (steps_i),
    .data_out_o  (data_out_o),
    .status_o    (status_o),
    .occupancy_o (occupancy_o)
  );

endmodule

/* src/crl_checker.sv */
module crl_checker #(
  parameter int unsigned CAPACITY = crl_pkg::CAPACITY_DEF,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [crl_pkg::DATA_W-1:0] data_out_o,
  input logic [1:0]                        status_o,
  input logic [CW-1:0]                     occupancy_o
);
  import crl_pkg::*;

  // A stalled result item holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(data_out_o)
      && $stable(status_o) && $stable(occupancy_o))
    else $error("result item changed while stalled");

  // A full refusal only happens with the pool full.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> occupancy_o == CW'(CAPACITY)
      && data_out_o == '0)
    else $error("full status with free nodes");

  // An empty flag only happens with an empty ring.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> occupancy_o == '0 && data_out_o == '0)
    else $error("empty status with nodes present");

  // Status codes and occupancy stay in range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3 && occupancy_o <= CW'(CAPACITY))
    else $error("result out of range");

endmodule

bind circular_doubly_linked_ring_core crl_checker #(.CAPACITY(CAPACITY)) u_crl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .data_out_o  (data_out_o),
  .status_o    (status_o),
  .occupancy_o (occupancy_o)
);
